// File: src/fk_pkg.sv
// shared types, constants and helpers for the six joint forward kinematics pipeline
package fk_pkg;

	localparam int STEPS = 30;
	localparam int ENT_W = 32;
	localparam int CW = 34;
	localparam int ANG_W = 36;
	localparam int Q13_W = 18;

	typedef logic signed [ENT_W-1:0] ent_t;
	typedef ent_t mat_t [3][3];
	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic signed [Q13_W-1:0] q13_t;

	localparam ent_t ONE_Q30 = 32'sd1073741824;
	localparam ang_t PI_Q30 = 36'sd3373259426;
	localparam ang_t HALF_PI_Q30 = 36'sd1686629713;
	localparam ang_t TWO_PI_Q30 = 36'sd6746518852;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam int PI_Q13 = 25736;
	localparam int HALF_PI_Q13 = 12868;
	localparam int POS_MAX = 1048575;
	localparam int POS_MIN = -1048576;

	localparam logic [29:0] ATAN_TAB [STEPS] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
		30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536,
		30'd32768, 30'd16384, 30'd8192, 30'd4096, 30'd2048,
		30'd1024, 30'd512, 30'd256, 30'd128, 30'd64,
		30'd32, 30'd16, 30'd8, 30'd4, 30'd2
	};

	// register indexes
	localparam logic [2:0] REG_BASE_HEIGHT = 3'd0;
	localparam logic [2:0] REG_UPPER_ARM = 3'd1;
	localparam logic [2:0] REG_FOREARM = 3'd2;
	localparam logic [2:0] REG_TOOL = 3'd3;
	localparam logic [2:0] REG_THRESHOLD = 3'd4;

	// stage counts
	localparam int SC_LAT = STEPS + 2;
	localparam int MM_LAT = 2;
	localparam int POS_LAT = 3;
	localparam int SQ_LAT = 33;
	localparam int AT_LAT = STEPS + 2;
	localparam int T_R05 = SC_LAT + 4 * MM_LAT;
	localparam int T_R06 = SC_LAT + 5 * MM_LAT;
	localparam int T_ORI = T_R06 + SQ_LAT + AT_LAT;
	localparam int PIPE_LAT = T_ORI + 1;

	function automatic ent_t clamp_q30(logic signed [63:0] v);
		ent_t r;
		if (v > 64'sd1073741824) begin
			r = ONE_Q30;
		end else if (v < -64'sd1073741824) begin
			r = -ONE_Q30;
		end else begin
			r = v[ENT_W-1:0];
		end
		return r;
	endfunction

	function automatic ent_t scl(ent_t v, int k);
		ent_t r;
		if (k > 0) begin
			r = v;
		end else if (k < 0) begin
			r = -v;
		end else begin
			r = '0;
		end
		return r;
	endfunction

	function automatic mat_t dh_mat(ent_t s, ent_t c, int ca, int sa);
		mat_t m;
		m[0][0] = c;
		m[0][1] = -scl(s, ca);
		m[0][2] = scl(s, sa);
		m[1][0] = s;
		m[1][1] = scl(c, ca);
		m[1][2] = -scl(c, sa);
		m[2][0] = '0;
		m[2][1] = scl(ONE_Q30, sa);
		m[2][2] = scl(ONE_Q30, ca);
		return m;
	endfunction

endpackage

// File: src/fk_delay.sv
// delay line that keeps side values aligned with the pipeline
module fk_delay #(
	parameter int W = 32,
	parameter int D = 2
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] line_q [D];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < D; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[D-1];
endmodule

// File: src/fk_sincos.sv
// pipelined rotation cordic giving sin and cos of one joint angle
module fk_sincos (
	input  logic         clk,
	input  logic         en,
	input  fk_pkg::ang_t theta,
	output fk_pkg::ent_t sin_o,
	output fk_pkg::ent_t cos_o
);
	import fk_pkg::*;

	logic signed [CW-1:0] x_s [STEPS+1];
	logic signed [CW-1:0] y_s [STEPS+1];
	ang_t z_s [STEPS+1];
	logic flip_s [STEPS+1];
	ang_t wr, fo;
	logic fl;
	logic signed [CW-1:0] xf, yf;

	always_comb begin
		wr = theta;
		if (theta > PI_Q30) begin
			wr = theta - TWO_PI_Q30;
		end else if (theta < -PI_Q30) begin
			wr = theta + TWO_PI_Q30;
		end
		fo = wr;
		fl = 1'b0;
		if (wr > HALF_PI_Q30) begin
			fo = wr - PI_Q30;
			fl = 1'b1;
		end else if (wr < -HALF_PI_Q30) begin
			fo = wr + PI_Q30;
			fl = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_GAIN;
			y_s[0] <= '0;
			z_s[0] <= fo;
			flip_s[0] <= fl;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - $signed({6'b0, ATAN_TAB[i]});
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + $signed({6'b0, ATAN_TAB[i]});
				end
			end
		end
	end

	assign xf = flip_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
	assign yf = flip_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			cos_o <= clamp_q30(64'(xf));
			sin_o <= clamp_q30(64'(yf));
		end
	end
endmodule

// File: src/fk_matmul.sv
// two stage 3x3 q1.30 matrix product with rounding and clamping
module fk_matmul (
	input  logic         clk,
	input  logic         en,
	input  fk_pkg::mat_t a,
	input  fk_pkg::mat_t b,
	output fk_pkg::mat_t p
);
	import fk_pkg::*;

	logic signed [63:0] prod_s1 [3][3][3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++) begin
						prod_s1[i][j][k] <= 64'(a[i][k]) * 64'(b[k][j]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p[i][j] <= clamp_q30((prod_s1[i][j][0] + prod_s1[i][j][1]
						+ prod_s1[i][j][2] + 64'sd536870912) >>> 30);
				end
			end
		end
	end
endmodule

// File: src/fk_isqrt.sv
// pipelined floor square root of r11^2 + r21^2, one result bit per stage
module fk_isqrt (
	input  logic         clk,
	input  logic         en,
	input  fk_pkg::ent_t r11,
	input  fk_pkg::ent_t r21,
	output logic [30:0]  mag
);
	import fk_pkg::*;

	localparam int NB = 31;

	logic signed [63:0] sq1_s1, sq2_s1;
	logic [61:0] rem_s [NB+1];
	logic [NB-1:0] rt_s [NB+1];

	always_ff @(posedge clk) begin
		if (en) begin
			sq1_s1 <= 64'(r11) * 64'(r11);
			sq2_s1 <= 64'(r21) * 64'(r21);
			rem_s[0] <= sq1_s1[61:0] + sq2_s1[61:0];
			rt_s[0] <= '0;
		end
	end

	for (genvar j = 0; j < NB; j++) begin : g_bit
		localparam int K = NB - 1 - j;
		logic [62:0] trial;
		assign trial = ({32'b0, rt_s[j]} << (K + 1)) + (63'd1 << (2 * K));
		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rem_s[j]} >= trial) begin
					rem_s[j+1] <= rem_s[j] - trial[61:0];
					rt_s[j+1] <= rt_s[j] | (NB'(1) << K);
				end else begin
					rem_s[j+1] <= rem_s[j];
					rt_s[j+1] <= rt_s[j];
				end
			end
		end
	end

	assign mag = rt_s[NB];
endmodule

// File: src/fk_atan2.sv
// pipelined vectoring cordic atan2, result rounded to q4.13
module fk_atan2 (
	input  logic         clk,
	input  logic         en,
	input  fk_pkg::ent_t y,
	input  fk_pkg::ent_t x,
	output fk_pkg::q13_t ang
);
	import fk_pkg::*;

	logic signed [CW-1:0] x_s [STEPS+1];
	logic signed [CW-1:0] y_s [STEPS+1];
	ang_t z_s [STEPS+1];
	ang_t zr;

	always_ff @(posedge clk) begin
		if (en) begin
			if (x < 0) begin
				x_s[0] <= -CW'(x);
				y_s[0] <= -CW'(y);
				z_s[0] <= (y >= 0) ? PI_Q30 : -PI_Q30;
			end else begin
				x_s[0] <= CW'(x);
				y_s[0] <= CW'(y);
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + $signed({6'b0, ATAN_TAB[i]});
				end else if (y_s[i] < 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - $signed({6'b0, ATAN_TAB[i]});
				end else begin
					x_s[i+1] <= x_s[i];
					y_s[i+1] <= y_s[i];
					z_s[i+1] <= z_s[i];
				end
			end
		end
	end

	assign zr = (z_s[STEPS] + 36'sd65536) >>> 17;

	always_ff @(posedge clk) begin
		if (en) begin
			ang <= zr[Q13_W-1:0];
		end
	end
endmodule

// File: src/six_joint_forward_kinematics.sv
// top level: six joint forward kinematics pipeline with apb register port
//
// channel   dir   handshake                  contents
// s_*       in    s_tvalid / s_tready        six joint angles
// m_*       out   m_tvalid / m_tready        tool position, yaw, pitch, roll, singular flag
// apb       in    psel, penable, pready      link lengths and singular threshold
//
// one word enters per cycle while the pipeline is not held; results leave in the order taken
// each word passes the sin/cos cordic, five chained matrix products, the square
// root and the atan2 cordic, each bit or product its own register stage
// the whole pipeline holds when the output word waits on m_tready
// reset clears the valid bits and loads the register defaults
module six_joint_forward_kinematics (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // joint1..joint6 angle, 16 b each, from bit 0
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,   // pos_x 21, pos_y 21, pos_z 21, yaw 16, pitch 15, roll 16, pad 2
	output logic [0:0]   m_tuser,   // singular
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import fk_pkg::*;

	logic adv;
	logic [PIPE_LAT:1] vld_q;
	logic [19:0] base_q, upper_q, fore_q, tool_q;
	logic [30:0] thr_q;

	ang_t theta [6];
	ent_t sin_w [6], cos_w [6];
	ent_t sin_d [6], cos_d [6];
	mat_t rr [6];
	mat_t pc [5];

	// config port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 20'd68157;
			upper_q <= 20'd112198;
			fore_q <= 20'd146801;
			tool_q <= 20'd181404;
			thr_q <= 31'd1074;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[4:2])
				REG_BASE_HEIGHT: base_q <= pwdata[19:0];
				REG_UPPER_ARM:   upper_q <= pwdata[19:0];
				REG_FOREARM:     fore_q <= pwdata[19:0];
				REG_TOOL:        tool_q <= pwdata[19:0];
				REG_THRESHOLD:   thr_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_BASE_HEIGHT: prdata = {12'b0, base_q};
			REG_UPPER_ARM:   prdata = {12'b0, upper_q};
			REG_FOREARM:     prdata = {12'b0, fore_q};
			REG_TOOL:        prdata = {12'b0, tool_q};
			REG_THRESHOLD:   prdata = {1'b0, thr_q};
			default:         prdata = '0;
		endcase
	end

	// pipeline control
	assign adv = !vld_q[PIPE_LAT] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[PIPE_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_LAT-1:1], s_tvalid};
		end
	end

	// joint angles to q30 and sin/cos
	for (genvar k = 0; k < 6; k++) begin : g_joint
		always_comb begin
			theta[k] = ANG_W'($signed(s_tdata[16*k +: 16])) <<< 17;
			if (k == 2 || k == 3) begin
				theta[k] = theta[k] + HALF_PI_Q30;
			end
		end
		fk_sincos u_sc (
			.clk(clk), .en(adv), .theta(theta[k]), .sin_o(sin_w[k]), .cos_o(cos_w[k])
		);
		if (k < 2) begin : g_now
			assign sin_d[k] = sin_w[k];
			assign cos_d[k] = cos_w[k];
		end else begin : g_late
			fk_delay #(.W(2 * ENT_W), .D(MM_LAT * (k - 1))) u_dly (
				.clk(clk), .en(adv), .d({sin_w[k], cos_w[k]}), .q({sin_d[k], cos_d[k]})
			);
		end
	end

	assign rr[0] = dh_mat(sin_d[0], cos_d[0], 0, 1);
	assign rr[1] = dh_mat(sin_d[1], cos_d[1], 1, 0);
	assign rr[2] = dh_mat(sin_d[2], cos_d[2], 0, 1);
	assign rr[3] = dh_mat(sin_d[3], cos_d[3], 0, 1);
	assign rr[4] = dh_mat(sin_d[4], cos_d[4], 0, -1);
	assign rr[5] = dh_mat(sin_d[5], cos_d[5], 1, 0);

	// chained rotations r02..r06
	for (genvar n = 0; n < 5; n++) begin : g_chain
		if (n == 0) begin : g_first
			fk_matmul u_mm (.clk(clk), .en(adv), .a(rr[0]), .b(rr[1]), .p(pc[0]));
		end else begin : g_next
			fk_matmul u_mm (.clk(clk), .en(adv), .a(pc[n-1]), .b(rr[n+1]), .p(pc[n]));
		end
	end

	// position
	ent_t v_d [3], f_d [3];
	logic signed [52:0] pu_s1 [3], pf_s1 [3], pt_s1 [3];
	logic signed [55:0] ps_s2 [3];
	logic signed [55:0] rnd [3];
	logic signed [20:0] pos_s3 [3];
	logic signed [20:0] pos_d [3];

	fk_delay #(.W(3 * ENT_W), .D(3 * MM_LAT)) u_vdly (
		.clk(clk), .en(adv),
		.d({pc[0][0][0], pc[0][1][0], pc[0][2][0]}),
		.q({v_d[0], v_d[1], v_d[2]})
	);
	fk_delay #(.W(3 * ENT_W), .D(2 * MM_LAT)) u_fdly (
		.clk(clk), .en(adv),
		.d({pc[1][0][2], pc[1][1][2], pc[1][2][2]}),
		.q({f_d[0], f_d[1], f_d[2]})
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pu_s1[i] <= 53'($signed({1'b0, upper_q})) * 53'(v_d[i]);
				pf_s1[i] <= 53'($signed({1'b0, fore_q})) * 53'(f_d[i]);
				pt_s1[i] <= 53'($signed({1'b0, tool_q})) * 53'(pc[3][i][2]);
				ps_s2[i] <= 56'(pu_s1[i]) + 56'(pf_s1[i]) + 56'(pt_s1[i]);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i] = (ps_s2[i] + 56'sd536870912) >>> 30;
		end
		rnd[2] = rnd[2] + $signed({36'b0, base_q});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (rnd[i] > 56'(POS_MAX)) begin
					pos_s3[i] <= 21'(POS_MAX);
				end else if (rnd[i] < 56'(POS_MIN)) begin
					pos_s3[i] <= 21'(POS_MIN);
				end else begin
					pos_s3[i] <= rnd[i][20:0];
				end
			end
		end
	end

	fk_delay #(.W(63), .D(T_ORI - T_R05 - POS_LAT)) u_pdly (
		.clk(clk), .en(adv),
		.d({pos_s3[0], pos_s3[1], pos_s3[2]}),
		.q({pos_d[0], pos_d[1], pos_d[2]})
	);

	// orientation
	logic [30:0] mag, mag_d;
	ent_t r11_d, r21_d, r31_d, r32_d, r33_d;
	q13_t yaw_w, pitch_w, roll_w;
	logic sing;

	fk_isqrt u_sqrt (
		.clk(clk), .en(adv), .r11(pc[4][0][0]), .r21(pc[4][1][0]), .mag(mag)
	);
	fk_delay #(.W(5 * ENT_W), .D(SQ_LAT)) u_rdly (
		.clk(clk), .en(adv),
		.d({pc[4][0][0], pc[4][1][0], pc[4][2][0], pc[4][2][1], pc[4][2][2]}),
		.q({r11_d, r21_d, r31_d, r32_d, r33_d})
	);
	fk_atan2 u_yaw (.clk(clk), .en(adv), .y(r21_d), .x(r11_d), .ang(yaw_w));
	fk_atan2 u_pitch (.clk(clk), .en(adv), .y(-r31_d), .x({1'b0, mag}), .ang(pitch_w));
	fk_atan2 u_roll (.clk(clk), .en(adv), .y(r32_d), .x(r33_d), .ang(roll_w));
	fk_delay #(.W(31), .D(AT_LAT)) u_mdly (.clk(clk), .en(adv), .d(mag), .q(mag_d));

	assign sing = mag_d < thr_q;

	// output word
	logic signed [15:0] yaw_q, roll_q;
	logic signed [14:0] pitch_q;
	logic sing_q;
	logic signed [20:0] pos_q [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= pos_d[i];
			end
			sing_q <= sing;
			if (pitch_w > 18'(HALF_PI_Q13)) begin
				pitch_q <= 15'(HALF_PI_Q13);
			end else if (pitch_w < -18'(HALF_PI_Q13)) begin
				pitch_q <= -15'(HALF_PI_Q13);
			end else begin
				pitch_q <= pitch_w[14:0];
			end
			if (sing) begin
				yaw_q <= '0;
				roll_q <= 16'(PI_Q13);
			end else begin
				if (yaw_w > 18'(PI_Q13)) begin
					yaw_q <= 16'(PI_Q13);
				end else if (yaw_w < -18'(PI_Q13)) begin
					yaw_q <= -16'(PI_Q13);
				end else begin
					yaw_q <= yaw_w[15:0];
				end
				if (roll_w > 18'(PI_Q13)) begin
					roll_q <= 16'(PI_Q13);
				end else if (roll_w < -18'(PI_Q13)) begin
					roll_q <= -16'(PI_Q13);
				end else begin
					roll_q <= roll_w[15:0];
				end
			end
		end
	end

	assign m_tdata = {2'b00, roll_q, pitch_q, yaw_q, pos_q[2], pos_q[1], pos_q[0]};
	assign m_tuser = sing_q;

`ifndef SYNTH
	a_sing_forced: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> yaw_q == 0 && roll_q == 16'(PI_Q13))
		else $error("singular word without forced yaw and roll");
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pitch_q <= 15'(HALF_PI_Q13) && pitch_q >= -15'(HALF_PI_Q13))
		else $error("pitch out of range");
	a_stall_holds_intake: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("intake open while output stalled");
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("intake closed with free output");
	a_word_moves: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[1])
		else $error("accepted word lost at first stage");
`endif
endmodule
